// ===== rtl/srsw_pkg.sv =====
package srsw_pkg;

	localparam int MAX_RESULTS = 8;
	localparam int WINDOW_DEF = 8;
	localparam int QUEUE_DEPTH_DEF = 16;
	localparam int SEQ_BITS_DEF = 16;

	localparam logic [15:0] TIMEOUT_RST = 16'd300;
	localparam logic [3:0] WINDOW_RST = 4'd8;

	localparam logic [1:0] FUNC_ENQ = 2'd0;
	localparam logic [1:0] FUNC_ACK = 2'd1;
	localparam logic [1:0] FUNC_TICK = 2'd2;

	localparam logic [1:0] KIND_FIRST = 2'd0;
	localparam logic [1:0] KIND_RESEND = 2'd1;
	localparam logic [1:0] KIND_REFUSED = 2'd2;

	localparam logic [1:0] REG_TIMEOUT = 2'd0;
	localparam logic [1:0] REG_WINDOW = 2'd1;

	typedef enum logic [1:0] {OP_ENQ, OP_ACK, OP_TICK} op_t;

	typedef struct packed {
		op_t op;
		logic [15:0] ack_seq;
		logic corrupt;
	} cmd_t;

	typedef struct packed {
		logic [15:0] fresh_timeout;
		logic [3:0] eff_window;
	} cfg_t;

endpackage

// ===== rtl/srsw_in_if.sv =====
interface srsw_in_if;
	logic valid;
	logic ready;
	logic [1:0] func;
	logic [15:0] ack_seq;
	logic ack_corrupt;
	modport source(output valid, output func, output ack_seq, output ack_corrupt, input ready);
	modport sink(input valid, input func, input ack_seq, input ack_corrupt, output ready);
endinterface

// ===== rtl/srsw_out_if.sv =====
interface srsw_out_if;
	logic valid;
	logic ready;
	logic [1:0] kind;
	logic [15:0] seq;
	logic last;
	modport source(output valid, output kind, output seq, output last, input ready);
	modport sink(input valid, input kind, input seq, input last, output ready);
endinterface

// ===== rtl/selective_repeat_sender_window.sv =====
// Selective-repeat ARQ sender window.
// in_ch carries events (func: enqueue, acknowledgement, tick); out_ch carries
// result beats (kind: first send, resend, refused; seq; last on the final beat
// of an event). Events that cause no result give no beat.
// Config: cfg_we/cfg_idx/cfg_data write timeout_ticks (0) or window_in_use (1);
// write only while the block is idle.
// An event enters a two-entry command queue, then a sequencer executes it:
// an enqueue is counted (or refused when the queue is full) and then sends the
// packets the window admits; an ack clears its slot, slides the window past
// the acked prefix, then sends; a tick walks every sent slot, counting down
// and resending the expired ones.
// The queue keeps taking events while the sequencer works, up to two ahead.
// If out_ch.ready is low, the held beat stays and the sequencer waits at the
// next beat it wants to issue; no beat is dropped.
// Reset clears the window, counters and queue; timeout returns to 300 ticks and
// window_in_use to 8.
module selective_repeat_sender_window import srsw_pkg::*; #(
	parameter int WINDOW = WINDOW_DEF,
	parameter int QUEUE_DEPTH = QUEUE_DEPTH_DEF
) (
	input logic clk,
	input logic arst_n,
	input logic cfg_we,
	input logic [1:0] cfg_idx,
	input logic [15:0] cfg_data,
	srsw_in_if.sink in_ch,
	srsw_out_if.source out_ch
);
	localparam int CAP = (WINDOW < MAX_RESULTS) ? WINDOW : MAX_RESULTS;

	logic [15:0] timeout_q;
	logic [3:0] window_q;
	cfg_t cfg;
	logic cmd_valid, cmd_ready;
	cmd_t cmd;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			timeout_q <= TIMEOUT_RST;
			window_q <= WINDOW_RST;
		end else if (cfg_we) begin
			if (cfg_idx == REG_TIMEOUT) timeout_q <= cfg_data;
			else if (cfg_idx == REG_WINDOW) window_q <= cfg_data[3:0];
		end
	end

	always_comb begin
		cfg.fresh_timeout = (timeout_q == 16'd0) ? 16'd1 : timeout_q;
		if (window_q == 4'd0) cfg.eff_window = 4'd1;
		else if (32'(window_q) > CAP) cfg.eff_window = 4'(CAP);
		else cfg.eff_window = window_q;
	end

	srsw_front u_front (
		.clk(clk), .arst_n(arst_n), .in_ch(in_ch),
		.cmd_valid(cmd_valid), .cmd(cmd), .cmd_ready(cmd_ready)
	);

	srsw_back #(.WINDOW(WINDOW), .QUEUE_DEPTH(QUEUE_DEPTH)) u_back (
		.clk(clk), .arst_n(arst_n), .cfg(cfg),
		.cmd_valid(cmd_valid), .cmd(cmd), .cmd_ready(cmd_ready), .out_ch(out_ch)
	);
endmodule

// ===== rtl/srsw_front.sv =====
module srsw_front import srsw_pkg::*; (
	input logic clk,
	input logic arst_n,
	srsw_in_if.sink in_ch,
	output logic cmd_valid,
	output cmd_t cmd,
	input logic cmd_ready
);
	cmd_t q_q [2];
	logic wr_q, rd_q;
	logic [1:0] cnt_q;
	logic push, pop;
	cmd_t c;

	assign in_ch.ready = (cnt_q != 2'd2);

	always_comb begin
		c.ack_seq = in_ch.ack_seq;
		c.corrupt = in_ch.ack_corrupt;
		unique case (in_ch.func)
			FUNC_ENQ: c.op = OP_ENQ;
			FUNC_ACK: c.op = OP_ACK;
			default: c.op = OP_TICK;
		endcase
	end

	// unknown events are taken and dropped here
	assign push = in_ch.valid && in_ch.ready && (in_ch.func != 2'd3);
	assign pop = cmd_valid && cmd_ready;
	assign cmd_valid = (cnt_q != 2'd0);
	assign cmd = q_q[rd_q];

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_q <= 1'b0;
			rd_q <= 1'b0;
			cnt_q <= 2'd0;
		end else begin
			if (push) begin
				q_q[wr_q] <= c;
				wr_q <= ~wr_q;
			end
			if (pop) rd_q <= ~rd_q;
			cnt_q <= cnt_q + 2'(push) - 2'(pop);
		end
	end
endmodule

// ===== rtl/srsw_back.sv =====
module srsw_back import srsw_pkg::*; #(
	parameter int WINDOW = WINDOW_DEF,
	parameter int QUEUE_DEPTH = QUEUE_DEPTH_DEF
) (
	input logic clk,
	input logic arst_n,
	input cfg_t cfg,
	input logic cmd_valid,
	input cmd_t cmd,
	output logic cmd_ready,
	srsw_out_if.source out_ch
);
	localparam int SEQ_BITS = SEQ_BITS_DEF;
	localparam int CAP = (WINDOW < MAX_RESULTS) ? WINDOW : MAX_RESULTS;
	localparam int SLOTS = (CAP < QUEUE_DEPTH) ? CAP : QUEUE_DEPTH;
	localparam int QW = $clog2(QUEUE_DEPTH + 1);
	localparam int SW = $clog2(SLOTS + 1);
	localparam int IW = (SLOTS > 1) ? $clog2(SLOTS) : 1;

	typedef enum logic [2:0] {S_IDLE, S_ENQ, S_ACK, S_SLIDE, S_SEND, S_TICK} state_t;

	state_t st_q;
	cmd_t cmd_q;
	logic [SEQ_BITS-1:0] base_q;
	logic [SW-1:0] sent_q, idx_q;
	logic [QW-1:0] queued_q;
	logic [SLOTS-1:0] wait_q;
	logic [15:0] cd_q [SLOTS];
	logic out_v_q, out_last_q;
	logic [1:0] out_kind_q;
	logic [15:0] out_seq_q;

	logic can_emit, ack_ok, send_ok, send_last, tick_later, beat_go;
	logic [SEQ_BITS-1:0] off, send_seq, tick_seq, refuse_seq;
	logic [IW-1:0] off_i, sent_i, idx_i;
	logic [SLOTS-1:0] expire;

	assign can_emit = !out_v_q || out_ch.ready;
	assign cmd_ready = (st_q == S_IDLE);
	assign out_ch.valid = out_v_q;
	assign out_ch.kind = out_kind_q;
	assign out_ch.seq = out_seq_q;
	assign out_ch.last = out_last_q;

	assign off = SEQ_BITS'(cmd_q.ack_seq) - base_q;
	assign off_i = off[IW-1:0];
	assign sent_i = sent_q[IW-1:0];
	assign idx_i = idx_q[IW-1:0];
	assign ack_ok = !cmd_q.corrupt && (32'(off) < 32'(cfg.eff_window))
		&& (32'(off) < 32'(sent_q)) && wait_q[off_i];
	assign send_seq = base_q + SEQ_BITS'(sent_q);
	assign tick_seq = base_q + SEQ_BITS'(idx_q);
	assign refuse_seq = base_q + SEQ_BITS'(queued_q);
	assign send_ok = (32'(sent_q) < 32'(cfg.eff_window)) && (32'(sent_q) < 32'(queued_q))
		&& (32'(sent_q) < SLOTS);
	assign send_last = (32'(sent_q) + 1 >= 32'(cfg.eff_window))
		|| (32'(sent_q) + 1 >= 32'(queued_q)) || (32'(sent_q) + 1 >= SLOTS);

	// a new beat is loaded into the output register this cycle
	assign beat_go = can_emit && (
		(st_q == S_ENQ && 32'(queued_q) >= QUEUE_DEPTH) ||
		(st_q == S_SEND && send_ok) ||
		(st_q == S_TICK && 32'(idx_q) < 32'(sent_q) && wait_q[idx_i]
			&& cd_q[idx_i] <= 16'd1));

	// slots that will resend on this tick; used to flag the final beat
	always_comb begin
		tick_later = 1'b0;
		for (int j = 0; j < SLOTS; j++) begin
			expire[j] = (j < 32'(sent_q)) && wait_q[j] && (cd_q[j] <= 16'd1);
			if (expire[j] && (j > 32'(idx_q))) tick_later = 1'b1;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			st_q <= S_IDLE;
			base_q <= '0;
			sent_q <= '0;
			idx_q <= '0;
			queued_q <= '0;
			wait_q <= '0;
			out_v_q <= 1'b0;
		end else begin
			if (beat_go) out_v_q <= 1'b1;
			else if (out_ch.ready) out_v_q <= 1'b0;
			unique case (st_q)
				S_IDLE: begin
					if (cmd_valid) begin
						cmd_q <= cmd;
						idx_q <= '0;
						unique case (cmd.op)
							OP_ENQ: st_q <= S_ENQ;
							OP_ACK: st_q <= S_ACK;
							default: st_q <= S_TICK;
						endcase
					end
				end
				S_ENQ: begin
					if (32'(queued_q) >= QUEUE_DEPTH) begin
						if (can_emit) begin
							out_kind_q <= KIND_REFUSED;
							out_seq_q <= 16'(refuse_seq);
							out_last_q <= 1'b1;
							st_q <= S_IDLE;
						end
					end else begin
						queued_q <= queued_q + QW'(1);
						st_q <= S_SEND;
					end
				end
				S_ACK: begin
					if (ack_ok) begin
						wait_q[off_i] <= 1'b0;
						st_q <= S_SLIDE;
					end else begin
						st_q <= S_IDLE;
					end
				end
				S_SLIDE: begin
					// one slot per cycle past the acked prefix
					if (sent_q != '0 && !wait_q[0]) begin
						for (int j = 0; j < SLOTS - 1; j++) begin
							wait_q[j] <= wait_q[j+1];
							cd_q[j] <= cd_q[j+1];
						end
						wait_q[SLOTS-1] <= 1'b0;
						base_q <= base_q + SEQ_BITS'(1);
						sent_q <= sent_q - SW'(1);
						queued_q <= queued_q - QW'(1);
					end else begin
						st_q <= S_SEND;
					end
				end
				S_SEND: begin
					if (!send_ok) begin
						st_q <= S_IDLE;
					end else if (can_emit) begin
						wait_q[sent_i] <= 1'b1;
						cd_q[sent_i] <= cfg.fresh_timeout;
						out_kind_q <= KIND_FIRST;
						out_seq_q <= 16'(send_seq);
						out_last_q <= send_last;
						sent_q <= sent_q + SW'(1);
					end
				end
				S_TICK: begin
					if (idx_q >= sent_q) begin
						st_q <= S_IDLE;
					end else if (!wait_q[idx_i]) begin
						idx_q <= idx_q + SW'(1);
					end else if (cd_q[idx_i] > 16'd1) begin
						cd_q[idx_i] <= cd_q[idx_i] - 16'd1;
						idx_q <= idx_q + SW'(1);
					end else if (can_emit) begin
						cd_q[idx_i] <= cfg.fresh_timeout;
						out_kind_q <= KIND_RESEND;
						out_seq_q <= 16'(tick_seq);
						out_last_q <= !tick_later;
						idx_q <= idx_q + SW'(1);
					end
				end
				default: st_q <= S_IDLE;
			endcase
		end
	end

	a_sent_le_queued: assert property (@(posedge clk) disable iff (!arst_n)
		32'(sent_q) <= 32'(queued_q)) else $error("more sent than queued");
	a_sent_le_slots: assert property (@(posedge clk) disable iff (!arst_n)
		32'(sent_q) <= SLOTS) else $error("sent count past slots");
	a_wait_in_sent: assert property (@(posedge clk) disable iff (!arst_n)
		(32'(wait_q) >> sent_q) == 0) else $error("waiting slot beyond sent packets");
	a_out_kind: assert property (@(posedge clk) disable iff (!arst_n)
		out_v_q |-> (out_kind_q != 2'd3)) else $error("bad result kind");
endmodule

// ===== verif/selective_repeat_sender_window_chk.sv =====
`timescale 1ns / 100ps
module selective_repeat_sender_window_chk import srsw_pkg::*; (
	input logic clk,
	input logic arst_n,
	input logic cfg_we,
	input logic [1:0] cfg_idx,
	input logic [15:0] cfg_data,
	srsw_in_if in_ch,
	srsw_out_if out_ch,
	output int fails,
	output int pending,
	output logic [15:0] base_view
);

	typedef struct {
		logic [1:0] kind;
		logic [15:0] seq;
		logic last;
	} sent_beat_t;

	sent_beat_t sent_expected[$];

	logic [15:0] timeout_reg;
	logic [3:0] win_reg;
	logic [15:0] base_seq;
	logic [15:0] next_seq;
	int queued;
	bit waiting [QUEUE_DEPTH_DEF];
	logic [15:0] countdown [QUEUE_DEPTH_DEF];
	int beats_now;

	assign base_view = base_seq;

	function automatic int eff_window();
		int w;
		w = win_reg;
		if (w < 1) w = 1;
		if (w > MAX_RESULTS) w = MAX_RESULTS;
		return w;
	endfunction

	function automatic logic [15:0] fresh_timeout();
		return (timeout_reg == 16'd0) ? 16'd1 : timeout_reg;
	endfunction

	function automatic int in_flight();
		logic [15:0] d;
		d = next_seq - base_seq;
		return d;
	endfunction

	function automatic void add_beat(logic [1:0] kind, logic [15:0] seq);
		sent_beat_t b;
		b.kind = kind;
		b.seq = seq;
		b.last = 1'b0;
		sent_expected.push_back(b);
		beats_now++;
	endfunction

	function automatic void send_admitted();
		int n;
		forever begin
			n = in_flight();
			if (n >= eff_window() || n >= queued || n >= QUEUE_DEPTH_DEF ||
					beats_now >= MAX_RESULTS)
				break;
			waiting[n] = 1'b1;
			countdown[n] = fresh_timeout();
			add_beat(KIND_FIRST, next_seq);
			next_seq = next_seq + 16'd1;
		end
	endfunction

	function automatic void window_step(logic [1:0] func, logic [15:0] ack, logic corrupt);
		logic [15:0] off;
		int sent;
		int s;
		beats_now = 0;
		sent = in_flight();
		if (func == FUNC_ENQ) begin
			if (queued >= QUEUE_DEPTH_DEF) begin
				add_beat(KIND_REFUSED, base_seq + 16'(queued));
			end else begin
				queued++;
				send_admitted();
			end
		end else if (func == FUNC_ACK) begin
			off = ack - base_seq;
			if (!corrupt && off < eff_window() && off < sent && off < QUEUE_DEPTH_DEF &&
					waiting[off]) begin
				waiting[off] = 1'b0;
				s = 0;
				while (s < sent && s < queued && !waiting[s]) s++;
				if (s > 0) begin
					for (int i = 0; i < QUEUE_DEPTH_DEF; i++) begin
						waiting[i] = (i + s < QUEUE_DEPTH_DEF) ? waiting[i + s] : 1'b0;
						countdown[i] = (i + s < QUEUE_DEPTH_DEF) ? countdown[i + s] : 16'd0;
					end
					base_seq = base_seq + 16'(s);
					queued -= s;
				end
				send_admitted();
			end
		end else if (func == FUNC_TICK) begin
			for (int i = 0; i < sent && i < QUEUE_DEPTH_DEF; i++) begin
				if (!waiting[i]) continue;
				if (countdown[i] > 16'd1) begin
					countdown[i]--;
				end else if (beats_now < MAX_RESULTS) begin
					countdown[i] = fresh_timeout();
					add_beat(KIND_RESEND, base_seq + 16'(i));
				end else begin
					countdown[i] = 16'd1;
				end
			end
		end
		if (beats_now > 0) sent_expected[sent_expected.size() - 1].last = 1'b1;
	endfunction

	always @(posedge clk or negedge arst_n) begin
		sent_beat_t e;
		if (!arst_n) begin
			timeout_reg = TIMEOUT_RST;
			win_reg = WINDOW_RST;
			base_seq = '0;
			next_seq = '0;
			queued = 0;
			for (int i = 0; i < QUEUE_DEPTH_DEF; i++) begin
				waiting[i] = 1'b0;
				countdown[i] = '0;
			end
			sent_expected.delete();
			fails = 0;
		end else begin
			if (out_ch.valid && out_ch.ready) begin
				if (sent_expected.size() == 0) begin
					fails++;
					if (fails <= 10)
						$display("unexpected beat: kind %0d seq %0d last %0d",
							out_ch.kind, out_ch.seq, out_ch.last);
				end else begin
					e = sent_expected[0];
					sent_expected.delete(0);
					if (out_ch.kind !== e.kind || out_ch.seq !== e.seq ||
							out_ch.last !== e.last) begin
						fails++;
						if (fails <= 10)
							$display("mismatch: exp kind %0d seq %0d last %0d, got %0d %0d %0d",
								e.kind, e.seq, e.last, out_ch.kind, out_ch.seq, out_ch.last);
					end
				end
			end
			if (in_ch.valid && in_ch.ready)
				window_step(in_ch.func, in_ch.ack_seq, in_ch.ack_corrupt);
			if (cfg_we) begin
				if (cfg_idx == REG_TIMEOUT) timeout_reg = cfg_data;
				else if (cfg_idx == REG_WINDOW) win_reg = cfg_data[3:0];
			end
		end
		pending = sent_expected.size();
	end

endmodule

// ===== verif/selective_repeat_sender_window_tb.sv =====
`timescale 1ns / 100ps
module selective_repeat_sender_window_tb import srsw_pkg::*; ();

	localparam logic [1:0] FUNC_NONE = 2'd3;
	localparam logic [1:0] REG_NONE = 2'd3;
	localparam int CYCLE_LIMIT = 300000;
	localparam int DRAIN_CYCLES = 40;

	logic clk;
	logic arst_n;
	logic cfg_we;
	logic [1:0] cfg_idx;
	logic [15:0] cfg_data;
	int fails;
	int pending;
	logic [15:0] base_view;
	int cycles;
	bit idle_on;

	srsw_in_if in_ch();
	srsw_out_if out_ch();

	selective_repeat_sender_window dut (
		.clk(clk), .arst_n(arst_n),
		.cfg_we(cfg_we), .cfg_idx(cfg_idx), .cfg_data(cfg_data),
		.in_ch(in_ch), .out_ch(out_ch)
	);

	selective_repeat_sender_window_chk chk (
		.clk(clk), .arst_n(arst_n),
		.cfg_we(cfg_we), .cfg_idx(cfg_idx), .cfg_data(cfg_data),
		.in_ch(in_ch), .out_ch(out_ch),
		.fails(fails), .pending(pending), .base_view(base_view)
	);

	always begin
		clk = 1'b1;
		#2;
		clk = 1'b0;
		#2;
	end

	always @(posedge clk) begin
		cycles++;
		if (cycles > CYCLE_LIMIT) begin
			$display("RESULT: ERROR");
			$finish;
		end
	end

	// receiver stalls in bursts
	int stall_left;
	always @(negedge clk) begin
		if (stall_left > 0) begin
			stall_left--;
			out_ch.ready <= 1'b0;
		end else if (idle_on && $urandom_range(0, 9) == 0) begin
			stall_left = $urandom_range(1, 14) - 1;
			out_ch.ready <= 1'b0;
		end else begin
			out_ch.ready <= 1'b1;
		end
	end

	task automatic push_event(logic [1:0] func, logic [15:0] ack, logic corrupt);
		if (idle_on && $urandom_range(0, 7) == 0) begin
			in_ch.valid <= 1'b0;
			repeat ($urandom_range(1, 14)) @(negedge clk);
		end
		in_ch.valid <= 1'b1;
		in_ch.func <= func;
		in_ch.ack_seq <= ack;
		in_ch.ack_corrupt <= corrupt;
		do @(posedge clk); while (!in_ch.ready);
		@(negedge clk);
	endtask

	// leaves cfg_we high; caller lowers it after the last write
	task automatic cfg_write(logic [1:0] idx, logic [15:0] data);
		cfg_we <= 1'b1;
		cfg_idx <= idx;
		cfg_data <= data;
		@(negedge clk);
	endtask

	task automatic wait_idle();
		in_ch.valid <= 1'b0;
		while (pending != 0) @(negedge clk);
		repeat (DRAIN_CYCLES) @(negedge clk);
	endtask

	task automatic random_events(int count);
		int r;
		logic [15:0] ack;
		for (int i = 0; i < count; i++) begin
			r = $urandom_range(0, 99);
			ack = ($urandom_range(0, 3) != 0) ? base_view + 16'($urandom_range(0, 9))
				: 16'($urandom);
			if (r < 36) push_event(FUNC_ENQ, 16'($urandom), 1'($urandom));
			else if (r < 70) push_event(FUNC_ACK, ack, $urandom_range(0, 9) == 0);
			else if (r < 96) push_event(FUNC_TICK, 16'($urandom), 1'($urandom));
			else push_event(FUNC_NONE, 16'($urandom), 1'($urandom));
		end
	endtask

	logic [15:0] phase_timeout [6] = '{16'd0, 16'd1, 16'd3, 16'd65535, 16'd2, 16'd5};
	logic [3:0] phase_window [6] = '{4'd0, 4'd1, 4'd4, 4'd15, 4'd8, 4'd3};

	initial begin
		cycles = 0;
		stall_left = 0;
		idle_on = 1'b1;
		arst_n = 1'b0;
		cfg_we = 1'b0;
		cfg_idx = REG_TIMEOUT;
		cfg_data = '0;
		in_ch.valid = 1'b0;
		in_ch.func = FUNC_ENQ;
		in_ch.ack_seq = '0;
		in_ch.ack_corrupt = 1'b0;
		out_ch.ready = 1'b0;
		repeat (9) @(posedge clk);
		@(negedge clk);
		arst_n <= 1'b1;
		@(negedge clk);

		// fill past the queue so the last enqueue is refused
		for (int i = 0; i < 17; i++) push_event(FUNC_ENQ, 16'hffff, 1'b1);
		push_event(FUNC_ACK, 16'd0, 1'b1);
		push_event(FUNC_ACK, 16'd12, 1'b0);
		push_event(FUNC_ACK, 16'd1, 1'b0);
		push_event(FUNC_ACK, 16'd0, 1'b0);
		push_event(FUNC_ACK, 16'd1, 1'b0);
		push_event(FUNC_TICK, 16'd0, 1'b0);
		push_event(FUNC_NONE, 16'hffff, 1'b1);
		wait_idle();

		for (int p = 0; p < 6; p++) begin
			cfg_write(REG_TIMEOUT, phase_timeout[p]);
			cfg_write(REG_WINDOW, {12'($urandom_range(0, 4095)), phase_window[p]});
			if (p == 2) cfg_write(REG_NONE, 16'($urandom));
			cfg_we <= 1'b0;
			@(negedge clk);
			idle_on = (p == 5) ? 1'b0 : (p != 2);
			random_events(43);
			wait_idle();
		end

		if (fails == 0 && pending == 0) begin
			$display("RESULT: OK");
		end else begin
			$display("RESULT: ERROR");
		end
		$finish;
	end

endmodule

// ===== sim.f =====
rtl/srsw_pkg.sv
rtl/srsw_in_if.sv
rtl/srsw_out_if.sv
rtl/srsw_front.sv
rtl/srsw_back.sv
rtl/selective_repeat_sender_window.sv
verif/selective_repeat_sender_window_chk.sv
verif/selective_repeat_sender_window_tb.sv
